/* design/ordered_keyword_match_macros.svh */
// assertion macros shared by the checker
`ifndef ORDERED_KEYWORD_MATCH_MACROS_SVH
`define ORDERED_KEYWORD_MATCH_MACROS_SVH

// same-cycle implication, disabled while in reset
`define OKM_ASSERT_NOW(name, clk, rst_n, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled while in reset
`define OKM_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* design/okm_pkg.sv */
// ----------------------------------------------------------------------------
// okm_pkg
// Types, constants and helpers shared by the ordered keyword match block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package okm_pkg;

	localparam int NUM_KEYS         = 4;
	localparam int KEY_BYTES        = 8;
	localparam int LEN_W            = 4;
	localparam int CNT_W            = 3;
	localparam int KEY_IDX_W        = 2;
	localparam int CFG_IDX_W        = 3;
	localparam int CFG_DATA_W       = 64;
	localparam int QUEUE_DEPTH      = 2;
	localparam int DEF_MAX_KEYWORDS = 4;
	localparam int DEF_MAX_KEY_LEN  = 8;

	localparam logic [7:0] CHAR_UPPER_A = 8'h41;
	localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
	localparam logic [7:0] CASE_OFFSET  = 8'h20;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_KEYWORD_A       = 3'd0,
		REG_KEYWORD_B       = 3'd1,
		REG_KEYWORD_C       = 3'd2,
		REG_KEYWORD_D       = 3'd3,
		REG_KEYWORD_LENGTHS = 3'd4,
		REG_KEYWORD_COUNT   = 3'd5
	} cfg_reg_t;

	typedef logic [7:0] byte_t;
	typedef byte_t [KEY_BYTES-1:0] key_t;

	// keyword set as the matcher sees it: folded bytes, clamped lengths and count
	typedef struct packed {
		key_t [NUM_KEYS-1:0]             key;
		logic [NUM_KEYS-1:0][LEN_W-1:0] len;
		logic [CNT_W-1:0]                count;
	} kw_cfg_t;

	typedef struct packed {
		byte_t text;
		logic  last;
	} qitem_t;

	function automatic byte_t fold(input byte_t c);
		byte_t r;
		r = c;
		if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) begin
			r = c + CASE_OFFSET;
		end
		return r;
	endfunction

endpackage

`default_nettype wire

/* design/okm_regs.sv */
// ----------------------------------------------------------------------------
// okm_regs
// Configuration registers: keywords stored folded, lengths and count clamped.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module okm_regs import okm_pkg::*; #(
	parameter int MAX_KEYWORDS = DEF_MAX_KEYWORDS,
	parameter int MAX_KEY_LEN  = DEF_MAX_KEY_LEN
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_valid,
	output logic                       cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	output kw_cfg_t                    cfg
);

	kw_cfg_t cfg_q;
	logic    wr_en;

	assign cfg_ready = 1'b1;
	assign wr_en     = cfg_valid && cfg_ready;
	assign cfg       = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (wr_en) begin
			unique case (cfg_index)
				REG_KEYWORD_A, REG_KEYWORD_B, REG_KEYWORD_C, REG_KEYWORD_D: begin
					for (int b = 0; b < KEY_BYTES; b++) begin
						cfg_q.key[KEY_IDX_W'(cfg_index)][b] <= fold(cfg_data[b*8 +: 8]);
					end
				end
				REG_KEYWORD_LENGTHS: begin
					for (int k = 0; k < NUM_KEYS; k++) begin
						if (cfg_data[k*LEN_W +: LEN_W] > LEN_W'(MAX_KEY_LEN)) begin
							cfg_q.len[k] <= LEN_W'(MAX_KEY_LEN);
						end else begin
							cfg_q.len[k] <= cfg_data[k*LEN_W +: LEN_W];
						end
					end
				end
				REG_KEYWORD_COUNT: begin
					if (cfg_data[CNT_W-1:0] > CNT_W'(MAX_KEYWORDS)) begin
						cfg_q.count <= CNT_W'(MAX_KEYWORDS);
					end else begin
						cfg_q.count <= cfg_data[CNT_W-1:0];
					end
				end
				default: begin
					// writes beyond the register list are dropped
				end
			endcase
		end
	end

endmodule

`default_nettype wire

/* design/okm_front.sv */
// ----------------------------------------------------------------------------
// okm_front
// Input side: takes text bytes, folds them to lower case, pushes the queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module okm_front import okm_pkg::*; (
	input  wire logic       in_valid,
	output logic            in_stall,
	input  wire logic [7:0] text_byte,
	input  wire logic       end_of_text,
	input  wire logic       q_full,
	output logic            q_push,
	output qitem_t          q_item
);

	assign in_stall    = q_full;
	assign q_push      = in_valid && !q_full;
	assign q_item.text = fold(text_byte);
	assign q_item.last = end_of_text;

endmodule

`default_nettype wire

/* design/okm_queue.sv */
// ----------------------------------------------------------------------------
// okm_queue
// Short request queue between the front and the matcher.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module okm_queue import okm_pkg::*; (
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire logic   push,
	input  wire qitem_t push_item,
	output logic        full,
	input  wire logic   pop,
	output logic        head_valid,
	output qitem_t      head_item
);

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_QW = $clog2(QUEUE_DEPTH + 1);

	qitem_t             entry_q [QUEUE_DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [CNT_QW-1:0]  count_q;
	logic               do_push;
	logic               do_pop;

	assign full       = count_q == CNT_QW'(QUEUE_DEPTH);
	assign head_valid = count_q != '0;
	assign head_item  = entry_q[rd_ptr_q];
	assign do_push    = push && !full;
	assign do_pop     = pop && head_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			unique case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

`default_nettype wire

/* design/okm_back.sv */
// ----------------------------------------------------------------------------
// okm_back
// Matcher: window compare against the current keyword, verdict register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module okm_back import okm_pkg::*; #(
	parameter int MAX_KEYWORDS = DEF_MAX_KEYWORDS,
	parameter int MAX_KEY_LEN  = DEF_MAX_KEY_LEN
) (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire kw_cfg_t cfg,
	input  wire logic    head_valid,
	input  wire qitem_t  head_item,
	output logic         pop,
	output logic         out_valid,
	input  wire logic    out_stall,
	output logic         matched
);

	localparam int NK_W      = $clog2(MAX_KEYWORDS + 1);
	localparam int BSM_W     = $clog2(MAX_KEY_LEN + 1);
	localparam int REC_DEPTH = (MAX_KEY_LEN > 1) ? MAX_KEY_LEN - 1 : 1;

	byte_t             rec_q [REC_DEPTH];
	logic [BSM_W-1:0]  bsm_q;
	logic [NK_W-1:0]   nk_q;
	logic              out_valid_q;
	logic              matched_q;

	logic              slot_free;
	logic [NK_W-1:0]   cnt_n;
	logic [NK_W-1:0]   nk_a;
	logic [NK_W-1:0]   nk_b;
	logic [BSM_W-1:0]  bsm_inc;
	logic [BSM_W-1:0]  bsm_n;
	logic [LEN_W-1:0]  cur_len;
	key_t              cur_key;
	byte_t             win [MAX_KEY_LEN];
	byte_t             have;
	logic              hit;
	logic              matched_n;

	assign slot_free = !out_valid_q || !out_stall;
	assign pop       = head_valid && (!head_item.last || slot_free);
	assign out_valid = out_valid_q;
	assign matched   = matched_q;
	assign cnt_n     = NK_W'(cfg.count);

	always_comb begin
		nk_a    = nk_q;
		// step past empty keywords before the compare
		for (int i = 0; i < MAX_KEYWORDS; i++) begin
			if (nk_a < cnt_n && cfg.len[KEY_IDX_W'(nk_a)] == '0) begin
				nk_a = nk_a + 1'b1;
			end
		end
		bsm_inc = (bsm_q < BSM_W'(MAX_KEY_LEN)) ? bsm_q + 1'b1 : bsm_q;
		cur_len = cfg.len[KEY_IDX_W'(nk_a)];
		cur_key = cfg.key[KEY_IDX_W'(nk_a)];
		win[0]  = head_item.text;
		for (int b = 1; b < MAX_KEY_LEN; b++) begin
			win[b] = rec_q[b-1];
		end
		hit = (nk_a < cnt_n) && (cur_len != '0) && (cur_len <= LEN_W'(bsm_inc));
		// key byte j lines up with the byte len-1-j positions back
		for (int j = 0; j < MAX_KEY_LEN; j++) begin
			have = '0;
			for (int b = 0; b < MAX_KEY_LEN; b++) begin
				if (b == int'(cur_len) - 1 - j) begin
					have = win[b];
				end
			end
			if (j < int'(cur_len) && have != cur_key[j]) begin
				hit = 1'b0;
			end
		end
		nk_b  = nk_a;
		bsm_n = bsm_inc;
		if (hit) begin
			nk_b  = nk_a + 1'b1;
			bsm_n = '0;
			for (int i = 0; i < MAX_KEYWORDS; i++) begin
				if (nk_b < cnt_n && cfg.len[KEY_IDX_W'(nk_b)] == '0) begin
					nk_b = nk_b + 1'b1;
				end
			end
		end
		matched_n = nk_b >= cnt_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < REC_DEPTH; i++) begin
				rec_q[i] <= '0;
			end
			bsm_q <= '0;
			nk_q  <= '0;
		end else if (pop) begin
			if (head_item.last) begin
				for (int i = 0; i < REC_DEPTH; i++) begin
					rec_q[i] <= '0;
				end
				bsm_q <= '0;
				nk_q  <= '0;
			end else begin
				rec_q[0] <= head_item.text;
				for (int i = 1; i < REC_DEPTH; i++) begin
					rec_q[i] <= rec_q[i-1];
				end
				bsm_q <= bsm_n;
				nk_q  <= nk_b;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pop && head_item.last) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop && head_item.last) begin
			matched_q <= matched_n;
		end
	end

endmodule

`default_nettype wire

/* design/ordered_keyword_match.sv */
// ----------------------------------------------------------------------------
// ordered_keyword_match
// Case-insensitive search for up to four keywords, in order, in a byte stream.
//
//   channel   direction  handshake             payload
//   text in   input      in_valid / in_stall   text_byte, end_of_text
//   verdict   output     out_valid / out_stall matched
//   config    input      cfg_valid / cfg_ready cfg_index, cfg_data
//
// One byte a cycle sustained; the matcher consumes one queued byte each cycle,
// its keyword pointer and window register closing the loop per byte.
// A verdict is registered once its last byte has passed the queue, when nothing waits.
// Reset clears the configuration, the match state and the two-entry queue.
// A stalled verdict holds the matcher only at the next last byte; text keeps
// flowing until the queue fills.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ordered_keyword_match import okm_pkg::*; #(
	parameter int MAX_KEYWORDS = DEF_MAX_KEYWORDS,
	parameter int MAX_KEY_LEN  = DEF_MAX_KEY_LEN
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  in_valid,
	output logic                       in_stall,
	input  wire logic [7:0]            text_byte,
	input  wire logic                  end_of_text,
	output logic                       out_valid,
	input  wire logic                  out_stall,
	output logic                       matched,
	input  wire logic                  cfg_valid,
	output logic                       cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data
);

	kw_cfg_t cfg;
	logic    q_full;
	logic    q_push;
	qitem_t  q_item;
	logic    q_pop;
	logic    q_head_valid;
	qitem_t  q_head_item;

	okm_regs #(
		.MAX_KEYWORDS (MAX_KEYWORDS),
		.MAX_KEY_LEN  (MAX_KEY_LEN)
	) u_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	okm_front u_front (
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.text_byte   (text_byte),
		.end_of_text (end_of_text),
		.q_full      (q_full),
		.q_push      (q_push),
		.q_item      (q_item)
	);

	okm_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_item  (q_item),
		.full       (q_full),
		.pop        (q_pop),
		.head_valid (q_head_valid),
		.head_item  (q_head_item)
	);

	okm_back #(
		.MAX_KEYWORDS (MAX_KEYWORDS),
		.MAX_KEY_LEN  (MAX_KEY_LEN)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.head_valid (q_head_valid),
		.head_item  (q_head_item),
		.pop        (q_pop),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.matched    (matched)
	);

endmodule

`default_nettype wire

/* design/okm_checker.sv */
// ----------------------------------------------------------------------------
// okm_checker
// Port-level checks on the ordered keyword match block, bound to the top.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "ordered_keyword_match_macros.svh"

module okm_checker import okm_pkg::*; (
	input wire logic                  clk,
	input wire logic                  arst_n,
	input wire logic                  in_valid,
	input wire logic                  in_stall,
	input wire logic                  end_of_text,
	input wire logic                  out_valid,
	input wire logic                  out_stall,
	input wire logic                  matched,
	input wire logic                  cfg_valid,
	input wire logic                  cfg_ready,
	input wire logic [CFG_IDX_W-1:0]  cfg_index,
	input wire logic [CFG_DATA_W-1:0] cfg_data
);

	logic [2:0] pending_q;
	logic       cnt_zero_q;
	logic       stall_q;
	logic       held_q;
	logic       last_acc;
	logic       out_acc;
	logic       hold;

	assign last_acc = in_valid && !in_stall && end_of_text;
	assign out_acc  = out_valid && !out_stall;
	assign hold     = out_valid && out_stall;

	// last bytes taken whose verdict is not yet delivered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= '0;
		end else begin
			pending_q <= pending_q + {2'b00, last_acc} - {2'b00, out_acc};
		end
	end

	// keyword count of zero means every verdict is a match
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_zero_q <= 1'b1;
		end else if (cfg_valid && cfg_ready && cfg_index == REG_KEYWORD_COUNT) begin
			cnt_zero_q <= cfg_data[CNT_W-1:0] == '0;
		end
	end

	// previous cycle's input stall and held verdict
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stall_q <= 1'b0;
			held_q  <= 1'b0;
		end else begin
			stall_q <= in_stall;
			held_q  <= hold;
		end
	end

	`OKM_ASSERT_NEXT(a_out_hold, clk, arst_n, hold, out_valid && $stable(matched), "verdict moved")
	`OKM_ASSERT_NOW(a_no_phantom, clk, arst_n, out_valid, pending_q != '0, "verdict without last")
	`OKM_ASSERT_NOW(a_stall_cause, clk, arst_n, in_stall && stall_q, held_q, "stall not from output")
	`OKM_ASSERT_NOW(a_zero_count, clk, arst_n, out_valid && cnt_zero_q, matched, "zero count no match")

endmodule

bind ordered_keyword_match okm_checker u_okm_checker (.*);

`default_nettype wire

/* tb/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for ordered_keyword_match. Text strings are streamed
// through the byte channel in random bursts while the verdict channel stalls
// on its own pattern. A shadow matcher works out the verdict of every string,
// and each verdict that leaves the block is checked against the oldest one.
// Keyword sets change between groups of strings, from fixed corner sets to random ones.
// ----------------------------------------------------------------------------
module tb_top import okm_pkg::*; ();

	localparam int DRAIN_CYCLES = 16;
	localparam int ITEM_GOAL    = 650;
	localparam int STRING_GOAL  = 40;

	typedef enum {TXT_ORDERED, TXT_BROKEN, TXT_NOISE, TXT_REVERSED} text_kind_t;
	typedef enum {STALL_NONE, STALL_RANDOM, STALL_SPARSE, STALL_HEAVY} stall_mode_t;

	// shadow matcher and the verdicts it still waits for
	class verdict_scoreboard;
		logic [63:0] keys [NUM_KEYS];
		logic [15:0] lens;
		logic [2:0]  count;
		byte_t       recent [KEY_BYTES-1];
		int unsigned since_match;
		int unsigned next_kw;
		bit          verdicts [$];
		int          errors;

		function new();
			foreach (keys[k]) keys[k] = '0;
			lens = '0;
			count = '0;
			errors = 0;
			clear_string();
		endfunction

		function void clear_string();
			foreach (recent[i]) recent[i] = '0;
			since_match = 0;
			next_kw = 0;
		endfunction

		function void write_reg(cfg_reg_t idx, logic [63:0] val);
			case (idx)
				REG_KEYWORD_A:       keys[0] = val;
				REG_KEYWORD_B:       keys[1] = val;
				REG_KEYWORD_C:       keys[2] = val;
				REG_KEYWORD_D:       keys[3] = val;
				REG_KEYWORD_LENGTHS: lens = val[15:0];
				REG_KEYWORD_COUNT:   count = val[2:0];
				default: ;
			endcase
		endfunction

		function byte_t lower(byte_t c);
			if (c >= "A" && c <= "Z") begin
				return c + 8'd32;
			end
			return c;
		endfunction

		function int unsigned used_count();
			return (count > DEF_MAX_KEYWORDS) ? DEF_MAX_KEYWORDS : int'(count);
		endfunction

		function int unsigned key_len(int unsigned k);
			int unsigned n;
			n = {28'd0, lens[4*k +: 4]};
			return (n > DEF_MAX_KEY_LEN) ? DEF_MAX_KEY_LEN : n;
		endfunction

		function void skip_empty();
			while (next_kw < used_count() && key_len(next_kw) == 0) next_kw++;
		endfunction

		function int pending();
			return verdicts.size();
		endfunction

		function void note_byte(byte_t b, bit last);
			byte_t       cur;
			byte_t       want;
			byte_t       have;
			int unsigned len;
			int unsigned back;
			int unsigned j;
			bit          hit;
			cur = lower(b);
			skip_empty();
			if (since_match < DEF_MAX_KEY_LEN) since_match++;
			if (next_kw < used_count()) begin
				len = key_len(next_kw);
				hit = (len != 0) && (len <= since_match);
				for (j = 0; hit && j < len; j++) begin
					want = lower(keys[next_kw][8*j +: 8]);
					back = len - 1 - j;
					have = (back == 0) ? cur : recent[back-1];
					if (want != have) hit = 0;
				end
				if (hit) begin
					next_kw++;
					since_match = 0;
					skip_empty();
				end
			end
			for (j = KEY_BYTES - 2; j > 0; j--) recent[j] = recent[j-1];
			recent[0] = cur;
			if (last) begin
				verdicts = {verdicts, bit'(next_kw >= used_count())};
				clear_string();
			end
		endfunction

		function void check_verdict(bit got);
			bit want;
			if (verdicts.size() == 0) begin
				$display("%0t: verdict with no string pending, expected none, actual %0b",
					$time, got);
				errors++;
			end else begin
				want = verdicts.pop_front();
				if (want != got) begin
					$display("%0t: matched wrong, expected %0b, actual %0b", $time, want, got);
					errors++;
				end
			end
		endfunction
	endclass

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  in_valid = 1'b0;
	logic                  in_stall;
	logic [7:0]            text_byte = '0;
	logic                  end_of_text = 1'b0;
	logic                  out_valid;
	logic                  out_stall = 1'b0;
	logic                  matched;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	verdict_scoreboard sb = new();
	int          burst_left = 0;
	int          random_bytes = 0;
	int          strings_sent = 0;
	int          stall_left = 0;
	stall_mode_t stall_mode = STALL_NONE;

	ordered_keyword_match dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.text_byte   (text_byte),
		.end_of_text (end_of_text),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.matched     (matched),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(negedge clk) begin
		if (stall_left == 0) begin
			stall_mode = stall_mode_t'($urandom_range(0, 3));
			stall_left = $urandom_range(20, 200);
		end
		stall_left--;
		case (stall_mode)
			STALL_NONE:   out_stall <= 1'b0;
			STALL_RANDOM: out_stall <= 1'($urandom_range(0, 1));
			STALL_SPARSE: out_stall <= ($urandom_range(0, 7) == 0);
			default:      out_stall <= ($urandom_range(0, 3) != 0);
		endcase
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			sb.check_verdict(matched);
		end
	end

	// called at a falling edge, returns at a falling edge
	task automatic push_byte(input byte_t b, input bit last);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 40);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
		burst_left--;
		in_valid <= 1'b1;
		text_byte <= b;
		end_of_text <= last;
		do @(posedge clk); while (in_stall);
		sb.note_byte(b, last);
		@(negedge clk);
	endtask

	task automatic push_text(input byte_t txt[$]);
		foreach (txt[i]) push_byte(txt[i], i == txt.size() - 1);
	endtask

	// let every verdict out and the matcher run dry before touching registers
	task automatic settle();
		in_valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic write_reg(input cfg_reg_t idx, input logic [63:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		sb.write_reg(idx, val);
		@(negedge clk);
		cfg_valid <= 1'b0;
		@(negedge clk);
	endtask

	task automatic load_keywords(input logic [63:0] ka, input logic [63:0] kb,
			input logic [63:0] kc, input logic [63:0] kd,
			input logic [15:0] lens, input logic [2:0] cnt);
		write_reg(REG_KEYWORD_A, ka);
		write_reg(REG_KEYWORD_B, kb);
		write_reg(REG_KEYWORD_C, kc);
		write_reg(REG_KEYWORD_D, kd);
		write_reg(REG_KEYWORD_LENGTHS, {48'd0, lens});
		write_reg(REG_KEYWORD_COUNT, {61'd0, cnt});
	endtask

	// small alphabet so that near misses and overlaps are common
	function automatic byte_t pick_char();
		byte_t c;
		if ($urandom_range(0, 7) == 0) begin
			return byte_t'($urandom_range(0, 255));
		end
		c = "a" + byte_t'($urandom_range(0, 4));
		return $urandom_range(0, 1) ? c - 8'd32 : c;
	endfunction

	function automatic byte_t flip_case(byte_t c);
		if (((c >= "a" && c <= "z") || (c >= "A" && c <= "Z")) && $urandom_range(0, 1)) begin
			return c ^ 8'h20;
		end
		return c;
	endfunction

	task automatic build_text(output byte_t txt[$]);
		text_kind_t  kind;
		int unsigned nkeys;
		int unsigned skip;
		int unsigned k;
		int unsigned len;
		int          r;
		nkeys = sb.used_count();
		r = $urandom_range(0, 9);
		kind = (r < 7) ? TXT_ORDERED : (r == 7) ? TXT_BROKEN :
			(r == 8) ? TXT_NOISE : TXT_REVERSED;
		skip = $urandom_range(0, NUM_KEYS - 1);
		txt = {};
		if (kind == TXT_NOISE) begin
			repeat ($urandom_range(1, 12)) txt = {txt, byte_t'($urandom_range(0, 255))};
		end else begin
			for (int i = 0; i < nkeys; i++) begin
				k = (kind == TXT_REVERSED) ? nkeys - 1 - i : i;
				repeat ($urandom_range(0, 3)) txt = {txt, pick_char()};
				len = sb.key_len(k);
				// truncated keyword
				if (kind == TXT_BROKEN && k == skip && len > 0) len--;
				for (int j = 0; j < len; j++) begin
					txt = {txt, flip_case(sb.keys[k][8*j +: 8])};
				end
			end
			repeat ($urandom_range(0, 3)) txt = {txt, pick_char()};
		end
		if (txt.size() == 0) txt = {txt, pick_char()};
	endtask

	function automatic logic [63:0] random_keyword(int unsigned len);
		logic [63:0] kw;
		kw = {$urandom, $urandom};
		for (int j = 0; j < len && j < KEY_BYTES; j++) kw[8*j +: 8] = pick_char();
		return kw;
	endfunction

	task automatic random_phase(input int p);
		logic [63:0] kw [NUM_KEYS];
		logic [15:0] lens;
		logic [2:0]  cnt;
		int          target;
		int          n;
		int          r;
		byte_t       txt [$];
		if (p == 0) begin
			foreach (kw[k]) kw[k] = '1;
			lens = '1;
			cnt = '1;
		end else if (p == 1) begin
			foreach (kw[k]) kw[k] = '0;
			lens = '0;
			cnt = 3'(NUM_KEYS);
		end else begin
			for (int k = 0; k < NUM_KEYS; k++) begin
				r = $urandom_range(0, 9);
				lens[4*k +: 4] = 4'((r == 0) ? 0 : (r == 1) ? $urandom_range(9, 15) :
					$urandom_range(1, DEF_MAX_KEY_LEN));
				kw[k] = random_keyword({28'd0, lens[4*k +: 4]});
			end
			r = $urandom_range(0, 9);
			cnt = 3'((r == 0) ? 0 : (r == 1) ? $urandom_range(5, 7) :
				$urandom_range(1, NUM_KEYS));
		end
		load_keywords(kw[0], kw[1], kw[2], kw[3], lens, cnt);
		target = $urandom_range(60, 120);
		n = 0;
		while (n < target) begin
			build_text(txt);
			push_text(txt);
			n += txt.size();
			random_bytes += txt.size();
			strings_sent++;
		end
		settle();
	endtask

	initial begin
		int p;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// no keywords in use: any string matches
		push_byte(8'h00, 1'b0);
		push_byte(8'hFF, 1'b1);
		settle();

		// empty second keyword, non-ascii third keyword compared exactly
		load_keywords(64'h5A5A_5A5A_5A5A_6241, 64'h0, 64'h0000_0000_0000_00C1,
			64'h7F7F_7F7F_7F7F_7F7F, 16'h8102, 3'd3);
		push_byte("A", 1'b0);
		push_byte("b", 1'b0);
		push_byte(8'hC1, 1'b1);
		push_byte("a", 1'b0);
		push_byte("B", 1'b0);
		push_byte(8'hE1, 1'b1);
		settle();

		// length and count above their limits, folding at the edges of A-Z
		load_keywords(64'h7B7A_6160_5B5A_4140, 64'h1, 64'h2, 64'h3, 16'h000F, 3'd7);
		push_text('{8'h40, 8'h61, 8'h7A, 8'h5B, 8'h60, 8'h41, 8'h5A, 8'h7B});
		settle();

		// count lowered in the middle of a string, past the keyword already found
		load_keywords(64'h71, 64'h72, 64'h0, 64'h0, 16'h0011, 3'd2);
		push_byte("Q", 1'b0);
		settle();
		write_reg(REG_KEYWORD_COUNT, 64'd1);
		push_byte("z", 1'b1);
		settle();

		p = 0;
		while (random_bytes < ITEM_GOAL || strings_sent < STRING_GOAL) begin
			random_phase(p);
			p++;
		end

		settle();
		if (sb.errors == 0) begin
			$display("tb_top OK");
		end else begin
			$display("tb_top NOT OK");
		end
		$finish;
	end

	initial begin
		#5_000_000;
		$display("%0t: timeout", $time);
		$display("tb_top NOT OK");
		$finish;
	end

endmodule

/* sim.f */
+incdir+design
design/okm_pkg.sv
design/okm_regs.sv
design/okm_front.sv
design/okm_queue.sv
design/okm_back.sv
design/ordered_keyword_match.sv
design/okm_checker.sv
tb/tb_top.sv
